// ----- rtl/frof_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Package: shared types and constants of the framed reading outlier filter.
package frof_pkg;

   localparam int BYTE_W  = 8;
   localparam int VAL_W   = 25;                      // microvolt values
   localparam int RAW_W   = 16;                      // raw reading
   localparam int PROD_W  = VAL_W + RAW_W;           // range * raw
   localparam int DVS_W   = BYTE_W + RAW_W;          // 65535 * gain
   localparam int QSTEP_W = $clog2(VAL_W + 1);       // divider step counter

   localparam int RECENT_DEPTH_DEF = 8;
   localparam int RESET_RUN_DEF    = 4;

   localparam logic [VAL_W-1:0]  MAX_RANGE_RST = 25'd20000000;
   localparam logic [BYTE_W-1:0] FRAME_LEN     = 8'd6;
   localparam logic [BYTE_W-1:0] TAG_W_CHR     = 8'h57;   // 'W'
   localparam logic [BYTE_W-1:0] TAG_S_CHR     = 8'h53;   // 'S'
   localparam logic [BYTE_W-1:0] TAG_K_CHR     = 8'h4B;   // 'K'

   typedef struct packed {
      logic [BYTE_W-1:0] chunk_len;
      logic [BYTE_W-1:0] tag_first;
      logic [BYTE_W-1:0] tag_second;
      logic [BYTE_W-1:0] tag_third;
      logic [BYTE_W-1:0] gain_byte;
      logic [BYTE_W-1:0] raw_high;
      logic [BYTE_W-1:0] raw_low;
   } req_payload_type;

   typedef enum logic [1:0] {
      OUT_FIRST   = 2'd0,
      OUT_ACCEPT  = 2'd1,
      OUT_HOLD    = 2'd2,
      OUT_RESTART = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [VAL_W-1:0] shown_value;
      logic [1:0]       outcome;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCALE,
      S_DIV,
      S_MUL,
      S_DIFF,
      S_DECIDE,
      S_RST_NEXT,
      S_PUSH_RD,
      S_PUSH_WR,
      S_FINISH
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/frof_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Restoring radix-2 divider, one quotient bit per cycle.
module frof_divider
   import frof_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [PROD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0]  divisor,
   output logic      [VAL_W-1:0]  quotient,
   output logic                   done
);

   logic [DVS_W-1:0]   rem_ff, rem_in;
   logic [VAL_W-1:0]   shf_ff, shf_in;
   logic [DVS_W-1:0]   dvs_ff, dvs_in;
   logic [QSTEP_W-1:0] step_ff, step_in;
   logic               done_ff, done_in;
   logic [DVS_W:0]     trial;
   logic [DVS_W:0]     trial_sub;

   // The quotient always fits VAL_W bits, so the upper dividend bits start
   // as a remainder already below the divisor.
   always_comb begin
      trial     = {rem_ff, shf_ff[VAL_W-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      rem_in    = rem_ff;
      shf_in    = shf_ff;
      dvs_in    = dvs_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in  = DVS_W'(dividend[PROD_W-1:VAL_W]);
         shf_in  = dividend[VAL_W-1:0];
         dvs_in  = divisor;
         step_in = QSTEP_W'(VAL_W);
      end else if (step_ff != '0) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial_sub[DVS_W-1:0];
            shf_in = {shf_ff[VAL_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            shf_in = {shf_ff[VAL_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         done_in = (step_ff == QSTEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = shf_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

// ----- rtl/framed_reading_outlier_filter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top level: frame check, scaling, closeness test and window/suspect upkeep.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_payload (req_payload_type)
//   rsp_      out        rsp_valid/rsp_stall  rsp_payload (rsp_payload_type)
//   csr_      in         csr_valid/csr_ready  csr_wdata (max_range_uv)
//
// Most of a valid frame's time goes to the 25 divider steps; a window
// restart passes each rebuilt entry through S_RST_NEXT, S_PUSH_RD, S_PUSH_WR.
// A rejected chunk is taken while idle and gives no transfer.
// req_stall is high from acceptance until the result sits in the output
// register; a stalled result holds the block in its final state.
// Synchronous reset empties the window and suspects and loads the range.
module framed_reading_outlier_filter_top
   import frof_pkg::*;
#(
   parameter int RECENT_DEPTH = RECENT_DEPTH_DEF,
   parameter int RESET_RUN    = RESET_RUN_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_payload_type  req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [VAL_W-1:0] csr_wdata
);

   localparam int WCNT_W  = $clog2(RECENT_DEPTH + 1);
   localparam int WSUM_W  = VAL_W + $clog2(RECENT_DEPTH);
   localparam int PTR_W   = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
   localparam int MPROD_W = VAL_W + WCNT_W;
   localparam int FIVE_W  = MPROD_W + 3;
   localparam int SLOTS   = (RESET_RUN > 1) ? RESET_RUN - 1 : 1;
   localparam int SCNT_W  = $clog2(SLOTS + 1);
   localparam int SIDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [WCNT_W-1:0] WIN_FULL = WCNT_W'(RECENT_DEPTH);
   localparam logic [SCNT_W-1:0] HOLD_MAX = SCNT_W'(RESET_RUN - 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(RECENT_DEPTH - 1);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   state_type           state_ff, state_in;
   logic [VAL_W-1:0]    max_range_ff, max_range_in;
   logic [RAW_W-1:0]    raw_ff, raw_in;
   logic [BYTE_W-1:0]   gain_ff, gain_in;
   logic [VAL_W-1:0]    v_ff, v_in;
   logic [MPROD_W-1:0]  mprod_ff, mprod_in;
   logic [MPROD_W-1:0]  diff_ff, diff_in;
   logic [WCNT_W-1:0]   wcnt_ff, wcnt_in;
   logic [WSUM_W-1:0]   wsum_ff, wsum_in;
   logic [PTR_W-1:0]    old_ptr_ff, old_ptr_in;
   logic [PTR_W-1:0]    new_ptr_ff, new_ptr_in;
   logic [SCNT_W-1:0]   scnt_ff, scnt_in;
   logic [SCNT_W-1:0]   sidx_ff, sidx_in;
   logic [VAL_W-1:0]    pval_ff, pval_in;
   logic                restart_ff, restart_in;
   outcome_type         out_ff, out_in;
   logic [VAL_W-1:0]    last_kept_ff, last_kept_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;
   logic [VAL_W-1:0]    rd_ff;

   logic [VAL_W-1:0]    win_mem [RECENT_DEPTH];
   logic [VAL_W-1:0]    susp_ff [SLOTS];
   logic                mem_we;
   logic                susp_we;

   logic                frame_ok;
   logic                div_start;
   logic [PROD_W-1:0]   div_dividend;
   logic [DVS_W-1:0]    div_divisor;
   logic [VAL_W-1:0]    div_q;
   logic                div_done;
   logic [MPROD_W-1:0]  sum_ext;
   logic [FIVE_W-1:0]   five_diff;

   frof_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .done     (div_done)
   );

   assign frame_ok = (req_payload.chunk_len == FRAME_LEN) &&
                     (req_payload.tag_first == TAG_W_CHR) &&
                     (req_payload.tag_second == TAG_S_CHR) &&
                     (req_payload.tag_third == TAG_K_CHR) &&
                     (req_payload.gain_byte != '0);

   assign div_start    = (state_ff == S_SCALE);
   assign div_dividend = PROD_W'(max_range_ff) * PROD_W'(raw_ff);
   // 65535 * gain as (gain << 16) - gain
   assign div_divisor  = {gain_ff, RAW_W'(0)} - DVS_W'(gain_ff);

   assign sum_ext   = MPROD_W'(wsum_ff);
   assign five_diff = (FIVE_W'(diff_ff) << 2) + FIVE_W'(diff_ff);

   always_comb begin
      state_in     = state_ff;
      max_range_in = max_range_ff;
      raw_in       = raw_ff;
      gain_in      = gain_ff;
      v_in         = v_ff;
      mprod_in     = mprod_ff;
      diff_in      = diff_ff;
      wcnt_in      = wcnt_ff;
      wsum_in      = wsum_ff;
      old_ptr_in   = old_ptr_ff;
      new_ptr_in   = new_ptr_ff;
      scnt_in      = scnt_ff;
      sidx_in      = sidx_ff;
      pval_in      = pval_ff;
      restart_in   = restart_ff;
      out_in       = out_ff;
      last_kept_in = last_kept_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      susp_we      = 1'b0;

      if (csr_valid && csr_ready) begin
         max_range_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && frame_ok) begin
               raw_in   = {req_payload.raw_high, req_payload.raw_low};
               gain_in  = req_payload.gain_byte;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               v_in = div_q;
               if (wcnt_ff == '0) begin
                  pval_in    = div_q;
                  out_in     = OUT_FIRST;
                  restart_in = 1'b0;
                  state_in   = S_PUSH_RD;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            mprod_in = MPROD_W'(v_ff) * MPROD_W'(wcnt_ff);
            state_in = S_DIFF;
         end
         S_DIFF: begin
            diff_in  = (mprod_ff >= sum_ext) ? mprod_ff - sum_ext : sum_ext - mprod_ff;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // an empty sum can never pass, which the compare gives for free
            if (five_diff < FIVE_W'(wsum_ff)) begin
               pval_in    = v_ff;
               out_in     = OUT_ACCEPT;
               scnt_in    = '0;
               restart_in = 1'b0;
               state_in   = S_PUSH_RD;
            end else if (scnt_ff < HOLD_MAX) begin
               susp_we  = 1'b1;
               scnt_in  = scnt_ff + 1'b1;
               out_in   = OUT_HOLD;
               state_in = S_FINISH;
            end else begin
               out_in     = OUT_RESTART;
               wcnt_in    = '0;
               wsum_in    = '0;
               old_ptr_in = '0;
               new_ptr_in = '0;
               sidx_in    = '0;
               restart_in = 1'b1;
               state_in   = S_RST_NEXT;
            end
         end
         S_RST_NEXT: begin
            // replay held suspects oldest first, then the new reading
            if (sidx_ff < scnt_ff) begin
               pval_in = susp_ff[sidx_ff[SIDX_W-1:0]];
               sidx_in = sidx_ff + 1'b1;
            end else begin
               pval_in    = v_ff;
               restart_in = 1'b0;
               scnt_in    = '0;
            end
            state_in = S_PUSH_RD;
         end
         S_PUSH_RD: begin
            state_in = S_PUSH_WR;
         end
         S_PUSH_WR: begin
            mem_we = 1'b1;
            if (wcnt_ff == WIN_FULL) begin
               wsum_in    = wsum_ff - WSUM_W'(rd_ff) + WSUM_W'(pval_ff);
               old_ptr_in = ptr_next(old_ptr_ff);
            end else begin
               wcnt_in = wcnt_ff + 1'b1;
               wsum_in = wsum_ff + WSUM_W'(pval_ff);
            end
            new_ptr_in   = ptr_next(new_ptr_ff);
            last_kept_in = pval_ff;
            state_in     = restart_ff ? S_RST_NEXT : S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.shown_value = last_kept_ff;
               rsp_data_in.outcome     = out_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_range_ff <= MAX_RANGE_RST;
         wcnt_ff      <= '0;
         wsum_ff      <= '0;
         old_ptr_ff   <= '0;
         new_ptr_ff   <= '0;
         scnt_ff      <= '0;
         sidx_ff      <= '0;
         restart_ff   <= 1'b0;
         last_kept_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_range_ff <= max_range_in;
         wcnt_ff      <= wcnt_in;
         wsum_ff      <= wsum_in;
         old_ptr_ff   <= old_ptr_in;
         new_ptr_ff   <= new_ptr_in;
         scnt_ff      <= scnt_in;
         sidx_ff      <= sidx_in;
         restart_ff   <= restart_in;
         last_kept_ff <= last_kept_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      gain_ff     <= gain_in;
      v_ff        <= v_in;
      mprod_ff    <= mprod_in;
      diff_ff     <= diff_in;
      pval_ff     <= pval_in;
      out_ff      <= out_in;
      rsp_data_ff <= rsp_data_in;
   end

   // window store: ring with registered read of the oldest entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[new_ptr_ff] <= pval_ff;
      end
      rd_ff <= win_mem[old_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (susp_we) begin
         susp_ff[scnt_ff[SIDX_W-1:0]] <= v_ff;
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign csr_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_wcnt_bound: assert property (@(posedge clock) disable iff (reset)
      wcnt_ff <= WIN_FULL)
      else $error("window count beyond depth");

   a_scnt_bound: assert property (@(posedge clock) disable iff (reset)
      scnt_ff <= SCNT_W'(SLOTS))
      else $error("suspect count beyond slots");

   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      (wcnt_ff == '0) |-> (wsum_ff == '0))
      else $error("empty window with nonzero sum");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FINISH) && (out_ff == OUT_RESTART)) |-> (scnt_ff == '0))
      else $error("suspects left after a window restart");

endmodule
`default_nettype wire
